// File: rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Needs nothing else; each macro takes the clock and active-low reset by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

// File: rtl/shmd_pkg.sv
// Package for the sync-hunting message deframer: types, constants, sync ROM builder.
// Depends on nothing.
`default_nettype none

package shmd_pkg;

    localparam int MAX_PACKET_DEF       = 128;
    localparam int SYNC_PATTERN_LEN_DEF = 12;
    localparam int SYNC_PATTERN_MAX     = 64;

    localparam int TYPE_BYTES      = 4;
    localparam int FIXED_MSG_LEN   = 8;
    localparam int SEND_HEADER_LEN = 9;
    localparam int TEXT_LEN        = 12;
    localparam int SYNC_MAX_LEN    = TYPE_BYTES + SYNC_PATTERN_MAX;
    localparam int SYNC_ADDR_W     = $clog2(SYNC_MAX_LEN);
    localparam int TEXT_ADDR_W     = $clog2(TEXT_LEN);

    // Message type codes
    localparam logic [1:0] TYPE_SYNC = 2'd0;
    localparam logic [1:0] TYPE_SEND = 2'd1;
    localparam logic [1:0] TYPE_CHAN = 2'd2;
    localparam logic [1:0] TYPE_ADDR = 2'd3;

    typedef logic [7:0] sync_rom_t [0:SYNC_MAX_LEN-1];
    typedef logic [7:0] sync_text_t [0:TEXT_LEN-1];

    localparam sync_text_t SYNC_TEXT = '{
        8'h48, 8'h65, 8'h6c, 8'h6c, 8'h6f, 8'h20,
        8'h74, 8'h68, 8'h65, 8'h72, 8'h65, 8'h21
    };

    typedef struct packed {
        logic       hunting;
        logic [7:0] pos;
        logic [1:0] mtype;
        logic [7:0] plen;
    } shmd_state_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [1:0] msg_type;
        logic       message_done;
        logic       sync_done;
        logic       framing_error;
        logic       in_sync;
    } shmd_result_t;

    // Expected byte at each sync message position: zero type bytes, then the
    // text repeated out to the pattern length. Evaluated at elaboration.
    function automatic sync_rom_t sync_rom_f(input int pattern_len);
        sync_rom_t              rom;
        logic [TEXT_ADDR_W-1:0] k;
        k = '0;
        for (int i = 0; i < SYNC_MAX_LEN; i++) begin
            if (i < TYPE_BYTES || i >= TYPE_BYTES + pattern_len) begin
                rom[SYNC_ADDR_W'(i)] = 8'h00;
            end
            else begin
                rom[SYNC_ADDR_W'(i)] = SYNC_TEXT[k];
                k = (k == TEXT_ADDR_W'(TEXT_LEN - 1)) ? '0 : k + 1'b1;
            end
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

// File: rtl/shmd_if.sv
// Valid/ready channel interfaces for the deframer: receive events in, results out.
// Depends on nothing.
`default_nettype none

interface shmd_rx_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] rx_byte;
    logic       line_break;

    modport source (output valid, output has_byte, output rx_byte, output line_break,
                    input ready);
    modport sink   (input valid, input has_byte, input rx_byte, input line_break,
                    output ready);
endinterface

interface shmd_msg_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic [1:0] msg_type;
    logic       message_done;
    logic       sync_done;
    logic       framing_error;
    logic       in_sync;

    modport source (output valid, output byte_valid, output data_byte, output byte_index,
                    output msg_type, output message_done, output sync_done,
                    output framing_error, output in_sync, input ready);
    modport sink   (input valid, input byte_valid, input data_byte, input byte_index,
                    input msg_type, input message_done, input sync_done,
                    input framing_error, input in_sync, output ready);
endinterface

`default_nettype wire

// File: rtl/shmd_step.sv
// Per-event decision logic of the deframer: next framing state and result flags.
// Depends on shmd_pkg.
`default_nettype none

module shmd_step #(
    parameter int MAX_PACKET       = shmd_pkg::MAX_PACKET_DEF,
    parameter int SYNC_PATTERN_LEN = shmd_pkg::SYNC_PATTERN_LEN_DEF
) (
    input  shmd_pkg::shmd_state_t  state,
    input  logic                   has_byte,
    input  logic [7:0]             rx_byte,
    input  logic                   line_break,
    output shmd_pkg::shmd_state_t  state_next,
    output shmd_pkg::shmd_result_t result
);
    import shmd_pkg::*;

    localparam int        SYNC_MSG_LEN = TYPE_BYTES + SYNC_PATTERN_LEN;
    localparam sync_rom_t SYNC_ROM     = sync_rom_f(SYNC_PATTERN_LEN);

    logic       hunt0;
    logic [7:0] pos0;
    logic [7:0] expected;
    logic       drop;
    logic       bad;
    logic [1:0] mtype_new;
    logic [7:0] plen_new;
    logic [8:0] total;
    logic [8:0] np;

    // A line break clears framing before the byte is looked at
    assign hunt0    = line_break | state.hunting;
    assign pos0     = line_break ? 8'd0 : state.pos;
    assign expected = SYNC_ROM[pos0[SYNC_ADDR_W-1:0]];
    assign np       = {1'b0, pos0} + 9'd1;

    always_comb
    begin
        drop      = 1'b0;
        bad       = 1'b0;
        mtype_new = state.mtype;
        plen_new  = state.plen;
        if (pos0 == 8'd0) begin
            if (rx_byte == 8'd0) begin
                drop = 1'b1;
            end
            else if (rx_byte > 8'd3) begin
                bad = 1'b1;
            end
            else begin
                mtype_new = rx_byte[1:0];
                plen_new  = 8'd0;
            end
        end
        else if (pos0 < 8'(TYPE_BYTES)) begin
            bad = (rx_byte != 8'd0);
        end
        else if (pos0 == 8'(TYPE_BYTES) && state.mtype == TYPE_SEND) begin
            if (rx_byte > 8'(MAX_PACKET)) begin
                bad = 1'b1;
            end
            else begin
                plen_new = rx_byte;
            end
        end
    end

    assign total = (mtype_new == TYPE_SEND) ? 9'(SEND_HEADER_LEN) + {1'b0, plen_new}
                                            : 9'(FIXED_MSG_LEN);

    always_comb
    begin
        state_next            = state;
        state_next.hunting    = hunt0;
        state_next.pos        = pos0;
        result                = '0;
        result.framing_error  = line_break;
        if (has_byte) begin
            result.byte_valid = 1'b1;
            result.data_byte  = rx_byte;
            result.byte_index = pos0;
            if (hunt0) begin
                if (rx_byte == expected) begin
                    if (np >= 9'(SYNC_MSG_LEN)) begin
                        state_next.pos     = 8'd0;
                        state_next.hunting = 1'b0;
                        result.sync_done   = 1'b1;
                    end
                    else begin
                        state_next.pos = np[7:0];
                    end
                end
                else begin
                    state_next.pos = 8'd0;
                end
            end
            else if (drop) begin
                // zero type byte: counts as the first byte of a sync message
                state_next.hunting = 1'b1;
                state_next.mtype   = TYPE_SYNC;
                state_next.pos     = 8'd1;
            end
            else if (bad) begin
                state_next.hunting   = 1'b1;
                state_next.pos       = 8'd0;
                result.framing_error = 1'b1;
            end
            else begin
                state_next.mtype = mtype_new;
                state_next.plen  = plen_new;
                result.msg_type  = mtype_new;
                if (np >= total) begin
                    state_next.pos      = 8'd0;
                    result.message_done = 1'b1;
                end
                else begin
                    state_next.pos = np[7:0];
                end
            end
        end
        result.in_sync = ~state_next.hunting;
    end

endmodule

`default_nettype wire

// File: rtl/sync_hunting_message_deframer.sv
// Sync-hunting message deframer: one UART receive event in, one result out.
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while results are taken, set by the single
// framing-state update between the two registers. Reset: asynchronous, active
// low; hunting for sync at position 0, both pipeline registers empty.
// Depends on shmd_pkg, shmd_if, shmd_step and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sync_hunting_message_deframer #(
    parameter int MAX_PACKET       = shmd_pkg::MAX_PACKET_DEF,
    parameter int SYNC_PATTERN_LEN = shmd_pkg::SYNC_PATTERN_LEN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    shmd_rx_if.sink     rx,
    shmd_msg_if.source  msg
);
    import shmd_pkg::*;

    localparam int SYNC_MSG_LEN = TYPE_BYTES + SYNC_PATTERN_LEN;

    // Input register
    logic         in_vld_reg;
    logic         in_vld_next;
    logic         has_byte_reg;
    logic [7:0]   rx_byte_reg;
    logic         line_break_reg;

    // Result register
    logic         out_vld_reg;
    logic         out_vld_next;
    shmd_result_t res_reg;

    // Framing state
    shmd_state_t  state_reg;
    shmd_state_t  state_next;
    shmd_result_t res_next;

    logic         advance;
    logic         rx_fire;
    logic         step_fire;

    // The result slot frees up when empty or being taken; the input register
    // then moves on, so a new request is taken while a result is still waiting
    // only if the input register itself is free.
    assign advance   = ~out_vld_reg | msg.ready;
    assign rx.ready  = ~in_vld_reg | advance;
    assign rx_fire   = rx.valid & rx.ready;
    assign step_fire = in_vld_reg & advance;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (rx_fire) begin
            in_vld_next = 1'b1;
        end
        else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    assign out_vld_next = advance ? in_vld_reg : out_vld_reg;

    shmd_step #(
        .MAX_PACKET       (MAX_PACKET),
        .SYNC_PATTERN_LEN (SYNC_PATTERN_LEN)
    ) u_step (
        .state      (state_reg),
        .has_byte   (has_byte_reg),
        .rx_byte    (rx_byte_reg),
        .line_break (line_break_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // Control state: handshake flags and the framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
            state_reg.hunting <= 1'b1;
            state_reg.pos     <= 8'd0;
            state_reg.mtype   <= TYPE_SYNC;
            state_reg.plen    <= 8'd0;
        end
        else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            // Advance the framing state only when the request leaves for the result slot
            if (step_fire) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: hold until the next transfer
    always_ff @(posedge clk)
    begin
        if (rx_fire) begin
            has_byte_reg   <= rx.has_byte;
            rx_byte_reg    <= rx.rx_byte;
            line_break_reg <= rx.line_break;
        end
        if (step_fire) begin
            res_reg <= res_next;
        end
    end

    assign msg.valid         = out_vld_reg;
    assign msg.byte_valid    = res_reg.byte_valid;
    assign msg.data_byte     = res_reg.data_byte;
    assign msg.byte_index    = res_reg.byte_index;
    assign msg.msg_type      = res_reg.msg_type;
    assign msg.message_done  = res_reg.message_done;
    assign msg.sync_done     = res_reg.sync_done;
    assign msg.framing_error = res_reg.framing_error;
    assign msg.in_sync       = res_reg.in_sync;

    // A completed sync message always leaves the block operational
    `ASSERT_IMPLIES(a_sync_done_in_sync, clk, rst_n,
        out_vld_reg && res_reg.sync_done, res_reg.in_sync)
    // A resync always leaves the block hunting
    `ASSERT_IMPLIES(a_error_hunting, clk, rst_n,
        out_vld_reg && res_reg.framing_error, !res_reg.in_sync)
    // Message completion only happens while operational
    `ASSERT_IMPLIES(a_done_in_sync, clk, rst_n,
        out_vld_reg && res_reg.message_done, res_reg.in_sync && res_reg.byte_valid)
    // While hunting the position stays inside the sync message
    `ASSERT_IMPLIES(a_hunt_pos, clk, rst_n,
        state_reg.hunting, state_reg.pos < 8'(SYNC_MSG_LEN))
    // A processed request always lands in the result slot
    `ASSERT_NEXT(a_step_lands, clk, rst_n, step_fire, out_vld_reg)

endmodule

`default_nettype wire
